[rtl/core/nss_pkg.sv]
`timescale 1ns / 1ps
// nss_pkg: types, constants and per-axis helper functions of the nine-slice mapper.
// No dependencies; used by every module of the block.
package nss_pkg;

   localparam int COORD_W    = 12;
   localparam int SIZE_W     = 13;
   localparam int PLEN_W     = 9;
   localparam int BORDER_W   = 8;
   localparam int INDEX_W    = 16;
   localparam int SEC_W      = 2;
   localparam int DIR_W      = 14;
   localparam int PERIOD_W   = 11;
   localparam int DIFF_W     = 13;
   localparam int MAG_W      = 12;
   localparam int REM_W      = 9;
   localparam int MID_W      = 11;
   localparam int PROD_W     = 18;
   localparam int SUM_W      = 19;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;

   localparam int STEP_BITS   = 4;
   localparam int DIV_STAGES  = MAG_W / STEP_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_DEPTH   = 8;
   localparam int OPTR_W      = $clog2(OUT_DEPTH);
   localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);
   localparam int PIPE_STAGES = DIV_STAGES + 2;
   localparam int FLIGHT_W    = $clog2(PIPE_STAGES + 1);
   localparam int CREDIT_W    = OCNT_W + 1;

   localparam logic [SEC_W-1:0] SEC_NEAR = 2'd0;
   localparam logic [SEC_W-1:0] SEC_MID  = 2'd1;
   localparam logic [SEC_W-1:0] SEC_FAR  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_RECT_WIDTH     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_RECT_HEIGHT    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PATTERN_WIDTH  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PATTERN_HEIGHT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_LEFT_BORDER    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_TOP_BORDER     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_RIGHT_BORDER   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_BOTTOM_BORDER  = 3'd7;

   localparam logic [SIZE_W-1:0]   RESET_RECT    = 13'd1;
   localparam logic [PLEN_W-1:0]   RESET_PATTERN = 9'd4;
   localparam logic [BORDER_W-1:0] RESET_BORDER  = 8'd1;

   localparam logic [SUM_W-1:0] INDEX_LIMIT = 19'd65535;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } req_word_type;

   typedef struct packed {
      logic [INDEX_W-1:0] source_index;
      logic [SEC_W-1:0]   col_section;
      logic [SEC_W-1:0]   row_section;
      logic               out_of_range;
   } rsp_word_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   rect_width;
      logic [SIZE_W-1:0]   rect_height;
      logic [PLEN_W-1:0]   pattern_width;
      logic [PLEN_W-1:0]   pattern_height;
      logic [BORDER_W-1:0] left_border;
      logic [BORDER_W-1:0] top_border;
      logic [BORDER_W-1:0] right_border;
      logic [BORDER_W-1:0] bottom_border;
   } cfg_type;

   // classified axis: near/far coordinate ready, middle needs a remainder
   typedef struct packed {
      logic [SEC_W-1:0]        sec;
      logic signed [DIR_W-1:0] dir;
      logic                    bad;
      logic                    neg;
      logic [MAG_W-1:0]        mag;
      logic [REM_W-1:0]        div;
      logic [PLEN_W-1:0]       plen;
      logic [BORDER_W-1:0]     base;
   } axis_cls_type;

   typedef struct packed {
      axis_cls_type col;
      axis_cls_type row;
   } cls_word_type;

   typedef struct packed {
      logic              ok;
      logic [REM_W-1:0]  coord;
   } axis_res_type;

   function automatic axis_cls_type classify_axis(
      input logic [COORD_W-1:0]  p,
      input logic [SIZE_W-1:0]   size,
      input logic [PLEN_W-1:0]   plen,
      input logic [BORDER_W-1:0] b1,
      input logic [BORDER_W-1:0] b2);
      axis_cls_type               r;
      logic [COORD_W-1:0]         half;
      logic                       near_hit;
      logic                       far_hit;
      logic signed [PERIOD_W-1:0] period;
      logic signed [DIFF_W-1:0]   diff;
      half     = size[SIZE_W-1:1];
      near_hit = (p < half) && (p < {4'b0, b1});
      // p >= max(half, size - b2) - 1, split into two parallel compares
      far_hit  = (({1'b0, p} + 13'd1) >= {1'b0, half}) &&
                 (({2'b0, p} + 14'd1 + {6'b0, b2}) >= {1'b0, size});
      period   = $signed({2'b0, plen}) - $signed({3'b0, b2}) - $signed({3'b0, b1})
                 - 11'sd1;
      diff     = $signed({1'b0, p}) - $signed({5'b0, b1});
      if (near_hit) begin
         r.sec = SEC_NEAR;
         r.dir = $signed({2'b0, p});
      end else if (far_hit) begin
         r.sec = SEC_FAR;
         r.dir = $signed({5'b0, plen}) - $signed({1'b0, size}) + $signed({2'b0, p});
      end else begin
         r.sec = SEC_MID;
         r.dir = '0;
      end
      r.bad  = period[PERIOD_W-1] || (period == 11'sd0);
      r.neg  = diff[DIFF_W-1];
      r.mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
      r.div  = period[REM_W-1:0];
      r.plen = plen;
      r.base = b1;
      return r;
   endfunction

   // restoring remainder, STEP_BITS dividend bits per call
   function automatic logic [REM_W-1:0] rem_step(
      input logic [REM_W-1:0]     rem,
      input logic [STEP_BITS-1:0] bits,
      input logic [REM_W-1:0]     d);
      logic [REM_W:0]   t;
      logic [REM_W-1:0] r;
      r = rem;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
         end
         r = t[REM_W-1:0];
      end
      return r;
   endfunction

   function automatic axis_res_type resolve_axis(
      input axis_cls_type     a,
      input logic [REM_W-1:0] rem);
      axis_res_type            r;
      logic signed [MID_W-1:0] mid;
      logic signed [DIR_W-1:0] c;
      // truncating remainder keeps the dividend's sign
      mid = a.neg ? $signed({3'b0, a.base}) - $signed({2'b0, rem})
                  : $signed({3'b0, a.base}) + $signed({2'b0, rem});
      c = (a.sec == SEC_MID) ? DIR_W'(mid) : a.dir;
      r.ok    = !((a.sec == SEC_MID) && a.bad) && !c[DIR_W-1] &&
                (c[DIR_W-2:0] < {4'b0, a.plen});
      r.coord = c[REM_W-1:0];
      return r;
   endfunction

endpackage

[rtl/core/nine_slice_source_index_top.sv]
`timescale 1ns / 1ps
// nine_slice_source_index_top: nine-slice pattern source index mapper, top level.
// Depends on nss_pkg, nss_csr, nss_front, nss_back.
//
//   channel   ports                               handshake
//   request   req_push req_full req_data          push & !full
//   response  rsp_empty rsp_pop rsp_data          pop & !empty
//   config    csr_valid csr_ready csr_index/data  valid & ready
//
// Sustains one word per cycle while the result queue has room; a word passes the queue,
// three 4-bit remainder stages, resolve and multiply before it shows on rsp_data.
// Reset is synchronous: config returns to defaults, both queues empty.
// The 2-word classify queue raises req_full; words enter the back pipeline only
// while the 8-word result queue can take every word in flight, so rsp_pop stalls
// never stop the pipeline.
module nine_slice_source_index_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  nss_pkg::req_word_type          req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output nss_pkg::rsp_word_type          rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nss_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [nss_pkg::CSR_DATA_W-1:0] csr_data
);
   import nss_pkg::*;

   cfg_type      cfg;
   logic         q_valid;
   cls_word_type q_word;
   logic         q_pop;

   nss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   nss_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_word   (q_word),
      .q_pop    (q_pop)
   );

   nss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_word    (q_word),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/nss_csr.sv]
`timescale 1ns / 1ps
// nss_csr: configuration register file of the nine-slice mapper.
// Depends on nss_pkg.
module nss_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nss_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [nss_pkg::CSR_DATA_W-1:0] csr_data,
   output nss_pkg::cfg_type               cfg
);
   import nss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_RECT_WIDTH:     cfg_in.rect_width     = csr_data[SIZE_W-1:0];
            REG_RECT_HEIGHT:    cfg_in.rect_height    = csr_data[SIZE_W-1:0];
            REG_PATTERN_WIDTH:  cfg_in.pattern_width  = csr_data[PLEN_W-1:0];
            REG_PATTERN_HEIGHT: cfg_in.pattern_height = csr_data[PLEN_W-1:0];
            REG_LEFT_BORDER:    cfg_in.left_border    = csr_data[BORDER_W-1:0];
            REG_TOP_BORDER:     cfg_in.top_border     = csr_data[BORDER_W-1:0];
            REG_RIGHT_BORDER:   cfg_in.right_border   = csr_data[BORDER_W-1:0];
            REG_BOTTOM_BORDER:  cfg_in.bottom_border  = csr_data[BORDER_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rect_width     <= RESET_RECT;
         cfg_ff.rect_height    <= RESET_RECT;
         cfg_ff.pattern_width  <= RESET_PATTERN;
         cfg_ff.pattern_height <= RESET_PATTERN;
         cfg_ff.left_border    <= RESET_BORDER;
         cfg_ff.top_border     <= RESET_BORDER;
         cfg_ff.right_border   <= RESET_BORDER;
         cfg_ff.bottom_border  <= RESET_BORDER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/nss_front.sv]
`timescale 1ns / 1ps
// nss_front: accepts request words, classifies both axes, holds them in a short queue.
// Depends on nss_pkg.
module nss_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  nss_pkg::req_word_type req_data,
   input  nss_pkg::cfg_type      cfg,
   output logic                  q_valid,
   output nss_pkg::cls_word_type q_word,
   input  logic                  q_pop
);
   import nss_pkg::*;

   cls_word_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wptr_ff;
   logic [QPTR_W-1:0]       wptr_in;
   logic [QPTR_W-1:0]       rptr_ff;
   logic [QPTR_W-1:0]       rptr_in;
   logic [QCNT_W-1:0]       cnt_ff;
   logic [QCNT_W-1:0]       cnt_in;
   cls_word_type            cls;
   logic                    push;
   logic                    pop;

   always_comb begin
      cls.col = classify_axis(req_data.col, cfg.rect_width, cfg.pattern_width,
                              cfg.left_border, cfg.right_border);
      cls.row = classify_axis(req_data.row, cfg.rect_height, cfg.pattern_height,
                              cfg.top_border, cfg.bottom_border);
   end

   assign req_full = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign q_word   = slot_ff[rptr_ff];
   assign push     = req_push && !req_full;
   assign pop      = q_pop && q_valid;

   always_comb begin
      wptr_in = push ? QPTR_W'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in = pop ? QPTR_W'(rptr_ff + 1'b1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= cls;
      end
   end

endmodule

[rtl/core/nss_back.sv]
`timescale 1ns / 1ps
// nss_back: remainder pipeline, coordinate resolve, index multiply and result queue.
// Depends on nss_pkg.
module nss_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  nss_pkg::cls_word_type q_word,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output nss_pkg::rsp_word_type rsp_data
);
   import nss_pkg::*;

   // remainder stages
   logic             dv_ff  [DIV_STAGES];
   logic             dv_in  [DIV_STAGES];
   cls_word_type     dw_ff  [DIV_STAGES];
   cls_word_type     dw_in  [DIV_STAGES];
   logic [REM_W-1:0] dcr_ff [DIV_STAGES];
   logic [REM_W-1:0] dcr_in [DIV_STAGES];
   logic [REM_W-1:0] drr_ff [DIV_STAGES];
   logic [REM_W-1:0] drr_in [DIV_STAGES];

   // resolve stage
   logic              rv_ff;
   axis_res_type      rcol_ff;
   axis_res_type      rcol_in;
   axis_res_type      rrow_ff;
   axis_res_type      rrow_in;
   logic [SEC_W-1:0]  rcs_ff;
   logic [SEC_W-1:0]  rrs_ff;
   logic [PLEN_W-1:0] rpw_ff;

   // multiply stage
   logic              mv_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [REM_W-1:0]  mcx_ff;
   logic              mok_ff;
   logic [SEC_W-1:0]  mcs_ff;
   logic [SEC_W-1:0]  mrs_ff;

   // result queue
   rsp_word_type      ofifo_ff [OUT_DEPTH];
   logic [OPTR_W-1:0] owp_ff;
   logic [OPTR_W-1:0] orp_ff;
   logic [OCNT_W-1:0] ocnt_ff;
   logic [OCNT_W-1:0] ocnt_in;

   logic [PIPE_STAGES-1:0] pipe_v;
   logic [FLIGHT_W-1:0]    inflight;
   logic [SUM_W-1:0]       sum;
   logic                   good;
   rsp_word_type           oword;
   logic                   opop;
   logic                   issue;

   // issue only with a guaranteed slot in the result queue
   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         pipe_v[s] = dv_ff[s];
      end
      pipe_v[DIV_STAGES]     = rv_ff;
      pipe_v[DIV_STAGES + 1] = mv_ff;
   end

   assign inflight = FLIGHT_W'($countones(pipe_v));
   assign issue    = q_valid &&
                     (({1'b0, ocnt_ff} + CREDIT_W'(inflight)) < CREDIT_W'(OUT_DEPTH));
   assign q_pop    = issue;

   always_comb begin
      dv_in[0]  = issue;
      dw_in[0]  = q_word;
      dcr_in[0] = rem_step('0, q_word.col.mag[MAG_W-1 -: STEP_BITS], q_word.col.div);
      drr_in[0] = rem_step('0, q_word.row.mag[MAG_W-1 -: STEP_BITS], q_word.row.div);
      for (int s = 1; s < DIV_STAGES; s++) begin
         dv_in[s]  = dv_ff[s-1];
         dw_in[s]  = dw_ff[s-1];
         dcr_in[s] = rem_step(dcr_ff[s-1],
                              dw_ff[s-1].col.mag[MAG_W-1-STEP_BITS*s -: STEP_BITS],
                              dw_ff[s-1].col.div);
         drr_in[s] = rem_step(drr_ff[s-1],
                              dw_ff[s-1].row.mag[MAG_W-1-STEP_BITS*s -: STEP_BITS],
                              dw_ff[s-1].row.div);
      end
   end

   assign rcol_in = resolve_axis(dw_ff[DIV_STAGES-1].col, dcr_ff[DIV_STAGES-1]);
   assign rrow_in = resolve_axis(dw_ff[DIV_STAGES-1].row, drr_ff[DIV_STAGES-1]);
   assign prod_in = {9'b0, rrow_ff.coord} * {9'b0, rpw_ff};

   always_comb begin
      sum                = {1'b0, prod_ff} + {10'b0, mcx_ff};
      good               = mok_ff && (sum <= INDEX_LIMIT);
      oword.source_index = good ? sum[INDEX_W-1:0] : '0;
      oword.col_section  = mcs_ff;
      oword.row_section  = mrs_ff;
      oword.out_of_range = !good;
   end

   assign rsp_empty = (ocnt_ff == '0);
   assign rsp_data  = ofifo_ff[orp_ff];
   assign opop      = rsp_pop && !rsp_empty;

   always_comb begin
      ocnt_in = ocnt_ff;
      if (mv_ff && !opop) begin
         ocnt_in = ocnt_ff + 1'b1;
      end else if (opop && !mv_ff) begin
         ocnt_in = ocnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_ff[s] <= 1'b0;
         end
         rv_ff   <= 1'b0;
         mv_ff   <= 1'b0;
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_ff[s] <= dv_in[s];
         end
         rv_ff   <= dv_ff[DIV_STAGES-1];
         mv_ff   <= rv_ff;
         owp_ff  <= mv_ff ? OPTR_W'(owp_ff + 1'b1) : owp_ff;
         orp_ff  <= opop ? OPTR_W'(orp_ff + 1'b1) : orp_ff;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         dw_ff[s]  <= dw_in[s];
         dcr_ff[s] <= dcr_in[s];
         drr_ff[s] <= drr_in[s];
      end
      rcol_ff <= rcol_in;
      rrow_ff <= rrow_in;
      rcs_ff  <= dw_ff[DIV_STAGES-1].col.sec;
      rrs_ff  <= dw_ff[DIV_STAGES-1].row.sec;
      rpw_ff  <= dw_ff[DIV_STAGES-1].col.plen;
      prod_ff <= prod_in;
      mcx_ff  <= rcol_ff.coord;
      mok_ff  <= rcol_ff.ok && rrow_ff.ok;
      mcs_ff  <= rcs_ff;
      mrs_ff  <= rrs_ff;
      if (mv_ff) begin
         ofifo_ff[owp_ff] <= oword;
      end
   end

endmodule

[rtl/core/nss_checker.sv]
`timescale 1ns / 1ps
// nss_checker: port-level assertions for nine_slice_source_index_top, plus its bind.
// Depends on nss_pkg.
module nss_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input nss_pkg::rsp_word_type rsp_data
);
   import nss_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_err_zero_index: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.out_of_range) |-> (rsp_data.source_index == '0))
      else $error("out_of_range word with nonzero index");

   a_sections_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.col_section <= SEC_FAR) && (rsp_data.row_section <= SEC_FAR))
      else $error("illegal section code");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_data))
      else $error("unpopped result word changed");

endmodule

bind nine_slice_source_index_top nss_checker u_nss_checker (.*);

[tb/tb_nine_slice_source_index_top.sv]
`timescale 1ns / 1ps
// tb_nine_slice_source_index_top: self-checking testbench of the nine-slice source index mapper.
// Depends on nss_pkg and nine_slice_source_index_top; a scoreboard class predicts every word.
module tb_nine_slice_source_index_top;
   import nss_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   class nine_slice_checker;
      cfg_type      cfg;
      rsp_word_type lookup_fifo[$];
      int           errors;

      function new();
         cfg.rect_width     = 13'd1;
         cfg.rect_height    = 13'd1;
         cfg.pattern_width  = 9'd4;
         cfg.pattern_height = 9'd4;
         cfg.left_border    = 8'd1;
         cfg.top_border     = 8'd1;
         cfg.right_border   = 8'd1;
         cfg.bottom_border  = 8'd1;
         errors = 0;
      endfunction

      function void write_reg(input logic [CSR_ADDR_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_RECT_WIDTH:     cfg.rect_width     = val[SIZE_W-1:0];
            REG_RECT_HEIGHT:    cfg.rect_height    = val[SIZE_W-1:0];
            REG_PATTERN_WIDTH:  cfg.pattern_width  = val[PLEN_W-1:0];
            REG_PATTERN_HEIGHT: cfg.pattern_height = val[PLEN_W-1:0];
            REG_LEFT_BORDER:    cfg.left_border    = val[BORDER_W-1:0];
            REG_TOP_BORDER:     cfg.top_border     = val[BORDER_W-1:0];
            REG_RIGHT_BORDER:   cfg.right_border   = val[BORDER_W-1:0];
            REG_BOTTOM_BORDER:  cfg.bottom_border  = val[BORDER_W-1:0];
            default: ;
         endcase
      endfunction

      // one axis: section, pattern coordinate and whether it is usable
      function void fold_axis(input int p, input int size, input int plen, input int b1,
                              input int b2, output logic [SEC_W-1:0] sec,
                              output int coord, output bit ok);
         int half;
         int near_end;
         int far_pos;
         int far_start;
         int period;
         half      = size / 2;
         near_end  = (half < b1) ? half : b1;
         far_pos   = size - b2;
         far_start = ((half > far_pos) ? half : far_pos) - 1;
         ok    = 1'b1;
         coord = 0;
         if (p < near_end) begin
            sec   = SEC_NEAR;
            coord = p;
         end else if (p >= far_start) begin
            sec   = SEC_FAR;
            coord = plen - (size - p);
         end else begin
            sec    = SEC_MID;
            period = plen - b2 - b1 - 1;
            if (period <= 0) begin
               ok = 1'b0;
            end else begin
               coord = b1 + (p - b1) % period;
            end
         end
         if (ok) begin
            ok = (coord >= 0) && (coord < plen);
         end
      endfunction

      function void note_pixel(input req_word_type w);
         rsp_word_type e;
         int           cx;
         int           cy;
         bit           okx;
         bit           oky;
         longint       idx;
         fold_axis(int'(w.col), int'(cfg.rect_width), int'(cfg.pattern_width),
                   int'(cfg.left_border), int'(cfg.right_border), e.col_section, cx, okx);
         fold_axis(int'(w.row), int'(cfg.rect_height), int'(cfg.pattern_height),
                   int'(cfg.top_border), int'(cfg.bottom_border), e.row_section, cy, oky);
         e.source_index = '0;
         e.out_of_range = 1'b1;
         if (okx && oky) begin
            idx = longint'(cy) * longint'(cfg.pattern_width) + longint'(cx);
            if (idx <= 65535) begin
               e.source_index = idx[INDEX_W-1:0];
               e.out_of_range = 1'b0;
            end
         end
         lookup_fifo.push_back(e);
      endfunction

      function void compare_field(input string name, input logic [15:0] want,
                                  input logic [15:0] seen);
         if (seen !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
         end
      endfunction

      function void check_lookup(input rsp_word_type got);
         rsp_word_type e;
         if (lookup_fifo.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, got %h", $time, got);
            return;
         end
         e = lookup_fifo.pop_front();
         compare_field("source_index", e.source_index, got.source_index);
         compare_field("col_section", e.col_section, got.col_section);
         compare_field("row_section", e.row_section, got.row_section);
         compare_field("out_of_range", e.out_of_range, got.out_of_range);
      endfunction

      function int pending();
         return lookup_fifo.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   req_word_type          req_data;
   logic                  rsp_empty;
   logic                  rsp_pop;
   rsp_word_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   nine_slice_checker board;
   int                send_idle;
   int                recv_idle;
   int                cycles;

   nine_slice_source_index_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            board.note_pixel(req_data);
         end
         if (rsp_pop && !rsp_empty) begin
            board.check_lookup(rsp_data);
         end
      end
   end

   always @(negedge clock) begin
      rsp_pop = ($urandom_range(99) >= recv_idle);
   end

   task automatic send_pixel(input int c, input int r);
      while ($urandom_range(99) < send_idle) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_data.col = c[COORD_W-1:0];
      req_data.row = r[COORD_W-1:0];
      req_push     = 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic drain();
      req_push = 1'b0;
      while (board.pending() > 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input int val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val[CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_cfg(input int rw, input int rh, input int pw, input int ph,
                            input int lb, input int tb, input int rb, input int bb);
      drain();
      write_csr(REG_RECT_WIDTH, rw);
      write_csr(REG_RECT_HEIGHT, rh);
      write_csr(REG_PATTERN_WIDTH, pw);
      write_csr(REG_PATTERN_HEIGHT, ph);
      write_csr(REG_LEFT_BORDER, lb);
      write_csr(REG_TOP_BORDER, tb);
      write_csr(REG_RIGHT_BORDER, rb);
      write_csr(REG_BOTTOM_BORDER, bb);
   endtask

   // biased toward both borders of the rectangle, with some pixels anywhere
   function automatic int pick_coord(input int size, input int b1, input int b2);
      int sel;
      int span;
      sel = $urandom_range(99);
      if (sel < 15) begin
         return $urandom_range(0, 4095);
      end else if (sel < 40) begin
         span = (size - 1 < b2 + 3) ? size - 1 : b2 + 3;
         return size - 1 - $urandom_range(0, span);
      end else if (sel < 55) begin
         span = (size - 1 < b1 + 3) ? size - 1 : b1 + 3;
         return $urandom_range(0, span);
      end
      return $urandom_range(0, size - 1);
   endfunction

   task automatic random_cfg(input int mode);
      case (mode)
         0: apply_cfg(4096, 4096, 256, 256, 255, 255, 255, 255);
         1: apply_cfg(1, 1, 1, 1, 0, 0, 0, 0);
         2: apply_cfg($urandom_range(1, 4096), $urandom_range(1, 4096),
                      $urandom_range(1, 256), $urandom_range(1, 256),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
         3: apply_cfg($urandom_range(64, 4096), $urandom_range(64, 4096),
                      $urandom_range(128, 256), $urandom_range(128, 256),
                      $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom_range(0, 0));
         default: apply_cfg($urandom_range(1, 64), $urandom_range(1, 64),
                            $urandom_range(1, 32), $urandom_range(1, 32),
                            $urandom_range(0, 12), $urandom_range(0, 12),
                            $urandom_range(0, 12), $urandom_range(0, 12));
      endcase
   endtask

   initial begin
      board     = new();
      cycles    = 0;
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      rsp_pop   = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      send_idle = 32;
      recv_idle = 70;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: 1x1 rect, every pixel in the far section
      send_pixel(0, 0);
      send_pixel(1, 0);
      send_pixel(4095, 4095);

      // all three sections on both axes
      apply_cfg(40, 30, 16, 12, 3, 2, 4, 3);
      send_pixel(0, 0);
      send_pixel(2, 1);
      send_pixel(3, 2);
      send_pixel(10, 15);
      send_pixel(34, 25);
      send_pixel(35, 26);
      send_pixel(39, 29);
      send_pixel(4095, 0);

      // negative remainder on columns, zero period on rows
      apply_cfg(20, 10, 32, 5, 15, 2, 0, 2);
      send_pixel(10, 1);
      send_pixel(12, 0);
      send_pixel(18, 9);
      send_pixel(9, 3);
      send_pixel(19, 7);

      // largest sizes, negative period, largest index
      apply_cfg(4096, 4096, 256, 256, 255, 255, 255, 255);
      send_pixel(4095, 4095);
      send_pixel(0, 0);
      send_pixel(254, 255);
      send_pixel(1000, 3840);
      send_pixel(3839, 2000);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 32 : (ph == 1) ? 70 : 0;
         recv_idle = (ph == 0) ? 70 : (ph == 1) ? 32 : 0;
         for (int seg = 0; seg < 5; seg++) begin
            random_cfg((seg + ph) % 5);
            repeat (100) begin
               send_pixel(pick_coord(int'(board.cfg.rect_width), int'(board.cfg.left_border),
                                     int'(board.cfg.right_border)),
                          pick_coord(int'(board.cfg.rect_height), int'(board.cfg.top_border),
                                     int'(board.cfg.bottom_border)));
            end
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/nss_pkg.sv
rtl/core/nss_csr.sv
rtl/core/nss_front.sv
rtl/core/nss_back.sv
rtl/core/nine_slice_source_index_top.sv
rtl/core/nss_checker.sv
tb/tb_nine_slice_source_index_top.sv
